/* src/ipv4_cidr_text_parser_unit_defines.svh */
// Assertion macros shared by the parser RTL.
`ifndef IPV4_CIDR_TEXT_PARSER_UNIT_DEFINES_SVH
`define IPV4_CIDR_TEXT_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ICP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ICP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/icp_pkg.sv */
// Types, constants and character helpers for the IPv4/CIDR text parser.
package icp_pkg;

  localparam int unsigned MAX_ADDR_CHARS_DEF = 15;
  localparam int unsigned PREFIX_SAT         = 64;

  typedef enum logic [1:0] {
    SEG_ADDR     = 2'd0,
    SEG_MASK     = 2'd1,
    SEG_ADDR_END = 2'd2,
    SEG_MASK_END = 2'd3
  } seg_e;

  typedef enum logic [2:0] {
    PH_EXPECT = 3'd0,
    PH_ZERO   = 3'd1,
    PH_OCT    = 3'd2,
    PH_DEC    = 3'd3,
    PH_HEXPRE = 3'd4,
    PH_HEX    = 3'd5,
    PH_DONE   = 3'd6,
    PH_FAIL   = 3'd7
  } num_ph_e;

  typedef enum logic [1:0] {
    PF_WS     = 2'd0,
    PF_DIGITS = 2'd1,
    PF_DONE   = 2'd3
  } pfx_ph_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_MASK   = 2'd1,
    ST_BAD_PREFIX = 2'd2,
    ST_BAD_ADDR   = 2'd3
  } status_e;

  // Number parser outcome: value is zero when not ok.
  typedef struct packed {
    logic        ok;
    logic [31:0] value;
  } num_res_t;

  // Control from the line scanner to the number parser.
  typedef struct packed {
    logic feed;
    logic clr;
  } num_ctl_t;

  typedef struct packed {
    logic [31:0] address;
    logic [31:0] mask;
    logic        mask_given;
    status_e     status;
  } res_t;

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  // Hex digit value, 16 when not a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    if (is_dig(c))                    v = 5'(c - "0");
    else if ((c >= "a") && (c <= "f")) v = 5'(c - "a" + 8'd10);
    else if ((c >= "A") && (c <= "F")) v = 5'(c - "A" + 8'd10);
    else                              v = 5'd16;
    return v;
  endfunction

endpackage

/* src/icp_if.sv */
// Word channels: character input and parse result output.
interface icp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;
  modport source (output valid, ch, last, input ready);
  modport sink   (input valid, ch, last, output ready);
endinterface

interface icp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;
  logic [31:0] mask;
  logic        mask_given;
  logic [1:0]  status;
  modport source (output valid, address, mask, mask_given, status, input ready);
  modport sink   (input valid, address, mask, mask_given, status, output ready);
endinterface

/* src/icp_num.sv */
// Dotted-quad number accumulator (decimal, octal, hex parts), one character per step.
module icp_num import icp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  num_ctl_t  ctl_i,
  input  logic [7:0] ch_i,
  output num_res_t  res_o
);

  num_ph_e     ph_q, ph_d, ph_f;
  logic [31:0] val_q, val_d, val_f;
  logic [1:0]  cnt_q, cnt_d, cnt_f;
  logic [7:0]  parts_q [3];
  logic [7:0]  parts_d [3];
  logic [7:0]  parts_f [3];

  logic        dig;
  logic [4:0]  hv;
  logic [3:0]  dv;
  logic [35:0] acc8, acc10, acc16;

  assign dig   = is_dig(ch_i);
  assign hv    = hex_val(ch_i);
  assign dv    = 4'(ch_i - "0");
  assign acc8  = {1'b0, val_q, 3'b0} + 36'(dv);
  assign acc10 = {1'b0, val_q, 3'b0} + {3'b0, val_q, 1'b0} + 36'(dv);
  assign acc16 = {val_q, 4'b0} + 36'(hv[3:0]);

  // State after this character, before any clear.
  always_comb begin
    ph_f    = ph_q;
    val_f   = val_q;
    cnt_f   = cnt_q;
    parts_f = parts_q;
    if (ctl_i.feed && ph_q != PH_FAIL && ph_q != PH_DONE) begin
      if (ch_i == ".") begin
        if (ph_q == PH_EXPECT || ph_q == PH_HEXPRE || cnt_q == 2'd3 ||
            val_q > 32'hFF) begin
          ph_f = PH_FAIL;
        end else begin
          parts_f[cnt_q] = val_q[7:0];
          cnt_f          = cnt_q + 2'd1;
          val_f          = '0;
          ph_f           = PH_EXPECT;
        end
      end else begin
        case (ph_q)
          PH_EXPECT: begin
            if (!dig) begin
              ph_f = PH_FAIL;
            end else if (ch_i == "0") begin
              val_f = '0;
              ph_f  = PH_ZERO;
            end else begin
              val_f = 32'(dv);
              ph_f  = PH_DEC;
            end
          end
          PH_ZERO, PH_OCT: begin
            if (ph_q == PH_ZERO && (ch_i == "x" || ch_i == "X")) begin
              ph_f = PH_HEXPRE;
            end else if (dig) begin
              if (ch_i > "7" || acc8[35:32] != 4'd0) begin
                ph_f = PH_FAIL;
              end else begin
                val_f = acc8[31:0];
                ph_f  = PH_OCT;
              end
            end else begin
              ph_f = is_space(ch_i) ? PH_DONE : PH_FAIL;
            end
          end
          PH_DEC: begin
            if (dig) begin
              if (acc10[35:32] != 4'd0) ph_f = PH_FAIL;
              else                      val_f = acc10[31:0];
            end else begin
              ph_f = is_space(ch_i) ? PH_DONE : PH_FAIL;
            end
          end
          PH_HEXPRE: begin
            if (!hv[4]) begin
              val_f = 32'(hv[3:0]);
              ph_f  = PH_HEX;
            end else begin
              ph_f = PH_FAIL;
            end
          end
          PH_HEX: begin
            if (!hv[4]) begin
              if (acc16[35:32] != 4'd0) ph_f = PH_FAIL;
              else                      val_f = acc16[31:0];
            end else begin
              ph_f = is_space(ch_i) ? PH_DONE : PH_FAIL;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Assemble the address from the parts, by part count.
  always_comb begin
    res_o = '0;
    if (ph_f != PH_EXPECT && ph_f != PH_HEXPRE && ph_f != PH_FAIL) begin
      case (cnt_f)
        2'd0: res_o = '{ok: 1'b1, value: val_f};
        2'd1: if (val_f <= 32'hFF_FFFF)
                res_o = '{ok: 1'b1, value: {parts_f[0], 24'd0} | val_f};
        2'd2: if (val_f <= 32'hFFFF)
                res_o = '{ok: 1'b1, value: {parts_f[0], parts_f[1], 16'd0} | val_f};
        default: if (val_f <= 32'hFF)
                res_o = '{ok: 1'b1,
                          value: {parts_f[0], parts_f[1], parts_f[2], 8'd0} | val_f};
      endcase
    end
  end

  always_comb begin
    ph_d    = ph_q;
    val_d   = val_q;
    cnt_d   = cnt_q;
    parts_d = parts_q;
    if (step_i) begin
      if (ctl_i.clr) begin
        ph_d    = PH_EXPECT;
        val_d   = '0;
        cnt_d   = '0;
        parts_d = '{default: '0};
      end else begin
        ph_d    = ph_f;
        val_d   = val_f;
        cnt_d   = cnt_f;
        parts_d = parts_f;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_EXPECT;
      val_q   <= '0;
      cnt_q   <= '0;
      parts_q <= '{default: '0};
    end else begin
      ph_q    <= ph_d;
      val_q   <= val_d;
      cnt_q   <= cnt_d;
      parts_q <= parts_d;
    end
  end

endmodule

/* src/icp_scan.sv */
// Line scanner: address/mask segments, prefix length, end-of-line result.
module icp_scan import icp_pkg::*; #(
  parameter int unsigned MAX_ADDR_CHARS = MAX_ADDR_CHARS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] ch_i,
  input  logic       last_i,
  output res_t       res_o
);

  localparam int unsigned KW = $clog2(MAX_ADDR_CHARS + 1);

  seg_e        seg_q, seg_d, seg_n;
  logic [KW-1:0] kept_q, kept_d, kept_n;
  logic [31:0] saved_q, saved_d, saved_n;
  logic        bad_q, bad_d, bad_n;
  logic [6:0]  pv_q, pv_d, pv_n;
  pfx_ph_e     pp_q, pp_d, pp_n;
  logic        dot_q, dot_d, dot_n;

  num_ctl_t    num_ctl;
  num_res_t    num_res;
  logic        dig;
  logic [9:0]  pv_acc;
  logic        given;

  assign dig    = is_dig(ch_i);
  assign pv_acc = {pv_q, 3'b0} + {2'b0, pv_q, 1'b0} + 10'(ch_i - "0");

  icp_num u_num (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step_i),
    .ctl_i  (num_ctl),
    .ch_i   (ch_i),
    .res_o  (num_res)
  );

  // Line state after this character.
  always_comb begin
    seg_n         = seg_q;
    kept_n        = kept_q;
    saved_n       = saved_q;
    bad_n         = bad_q;
    pv_n          = pv_q;
    pp_n          = pp_q;
    dot_n         = dot_q;
    num_ctl.feed  = 1'b0;
    num_ctl.clr   = last_i;
    if (ch_i == 8'd0) begin
      if (seg_q == SEG_ADDR)      seg_n = SEG_ADDR_END;
      else if (seg_q == SEG_MASK) seg_n = SEG_MASK_END;
    end else if (seg_q == SEG_ADDR) begin
      if (ch_i == "/") begin
        bad_n       = !num_res.ok;
        saved_n     = num_res.value;
        num_ctl.clr = 1'b1;
        seg_n       = SEG_MASK;
      end else if ((dig || ch_i == ".") && kept_q < KW'(MAX_ADDR_CHARS)) begin
        kept_n       = kept_q + 1'b1;
        num_ctl.feed = 1'b1;
      end
    end else if (seg_q == SEG_MASK) begin
      if (ch_i == ".") dot_n = 1'b1;
      num_ctl.feed = 1'b1;
      case (pp_q)
        PF_WS: begin
          if (!is_space(ch_i)) begin
            if (ch_i == "+") begin
              pp_n = PF_DIGITS;
            end else if (dig) begin
              pv_n = 7'(ch_i - "0");
              pp_n = PF_DIGITS;
            end else begin
              pv_n = '0;
              pp_n = PF_DONE;
            end
          end
        end
        PF_DIGITS: begin
          if (dig) pv_n = (pv_acc > 10'(PREFIX_SAT)) ? 7'(PREFIX_SAT) : pv_acc[6:0];
          else     pp_n = PF_DONE;
        end
        default: ;
      endcase
    end
  end

  // Result at the line's last character; mask is checked before address.
  always_comb begin
    given = (seg_n == SEG_MASK) || (seg_n == SEG_MASK_END);
    res_o = '{address: '0, mask: '0, mask_given: given, status: ST_OK};
    if (given) begin
      if (dot_n) begin
        if (!num_res.ok) res_o.status = ST_BAD_MASK;
        else             res_o.mask   = num_res.value;
      end else if (pv_n < 7'd1 || pv_n > 7'd32) begin
        res_o.status = ST_BAD_PREFIX;
      end else begin
        res_o.mask = ~(32'hFFFF_FFFF >> pv_n[5:0]);
      end
      if (res_o.status == ST_OK) begin
        if (bad_n) res_o.status  = ST_BAD_ADDR;
        else       res_o.address = saved_n;
      end
    end else begin
      if (num_res.ok) res_o.address = num_res.value;
      else            res_o.status  = ST_BAD_ADDR;
    end
  end

  always_comb begin
    seg_d   = seg_q;
    kept_d  = kept_q;
    saved_d = saved_q;
    bad_d   = bad_q;
    pv_d    = pv_q;
    pp_d    = pp_q;
    dot_d   = dot_q;
    if (step_i) begin
      if (last_i) begin
        seg_d   = SEG_ADDR;
        kept_d  = '0;
        saved_d = '0;
        bad_d   = 1'b0;
        pv_d    = '0;
        pp_d    = PF_WS;
        dot_d   = 1'b0;
      end else begin
        seg_d   = seg_n;
        kept_d  = kept_n;
        saved_d = saved_n;
        bad_d   = bad_n;
        pv_d    = pv_n;
        pp_d    = pp_n;
        dot_d   = dot_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q   <= SEG_ADDR;
      kept_q  <= '0;
      saved_q <= '0;
      bad_q   <= 1'b0;
      pv_q    <= '0;
      pp_q    <= PF_WS;
      dot_q   <= 1'b0;
    end else begin
      seg_q   <= seg_d;
      kept_q  <= kept_d;
      saved_q <= saved_d;
      bad_q   <= bad_d;
      pv_q    <= pv_d;
      pp_q    <= pp_d;
      dot_q   <= dot_d;
    end
  end

endmodule

/* src/ipv4_cidr_text_parser_unit.sv */
// IPv4 address / CIDR text parser. One character word per cycle enters an
// input register, save that a last word waits there for a free result slot;
// the line scanner (digit/dot accumulator with constant-base multiply-add,
// prefix counter) updates its state from that register, and when the word is
// marked last the parse result and out_o.valid are loaded into the output
// register. Sustained rate is one word per cycle while no last word waits.
// Input stays open while a finished result waits, until a second last word
// reaches the input register behind it.
// Status codes: ok, bad dotted mask, prefix out of range, bad address; on a
// mask error both address and mask read zero, on an address error the mask
// is kept. The bytes before '/' that are not digits or dots are skipped, and
// at most MAX_ADDR_CHARS digits/dots are kept. A zero byte ends the text.
`include "ipv4_cidr_text_parser_unit_defines.svh"

module ipv4_cidr_text_parser_unit import icp_pkg::*; #(
  parameter int unsigned MAX_ADDR_CHARS = MAX_ADDR_CHARS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  icp_in_if.sink           in_i,
  icp_out_if.source        out_o
);

  // Input register.
  logic       in_v_q;
  logic [7:0] in_ch_q;
  logic       in_last_q;

  // Output register.
  logic       out_v_q;
  res_t       res_q;

  res_t       res;
  logic       advance;

  // A non-last word never waits; a last word waits for a free result slot.
  assign advance     = in_v_q && (!in_last_q || !out_v_q || out_o.ready);
  assign in_i.ready  = !in_v_q || advance;

  icp_scan #(
    .MAX_ADDR_CHARS (MAX_ADDR_CHARS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .ch_i   (in_ch_q),
    .last_i (in_last_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.ready) begin
      in_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_ch_q   <= in_i.ch;
      in_last_q <= in_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      res_q <= res;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.address    = res_q.address;
  assign out_o.mask       = res_q.mask;
  assign out_o.mask_given = res_q.mask_given;
  assign out_o.status     = res_q.status;

  `ICP_ASSERT_IMP(a_nonlast_moves, in_v_q && !in_last_q, advance,
                  "non-last word stalled in input register")
  `ICP_ASSERT_NXT(a_last_loads, advance && in_last_q, out_v_q,
                  "line end did not produce a result")
  `ICP_ASSERT_IMP(a_mask_err_zero,
                  out_v_q && (res_q.status == ST_BAD_MASK || res_q.status == ST_BAD_PREFIX),
                  res_q.address == 32'd0 && res_q.mask == 32'd0,
                  "mask error result carries nonzero fields")
  `ICP_ASSERT_IMP(a_no_mask_zero, out_v_q && !res_q.mask_given, res_q.mask == 32'd0,
                  "mask set without a mask part")

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for the IPv4/CIDR text parser: line stimulus, in-bench parse model.
module tb;
  import icp_pkg::*;

  localparam int unsigned RANDOM_WORDS = 950;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [31:0] MASK_ONES    = 32'hFFFF_FFFF;
  localparam logic [63:0] WORD_MAX     = 64'hFFFF_FFFF;

  // Idle / stall percentages per traffic phase.
  localparam int unsigned SEND_IDLE [4] = '{0, 45, 0, 38};
  localparam int unsigned RECV_STALL[4] = '{0, 0, 45, 38};

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  icp_in_if  in_bus ();
  icp_out_if out_bus ();

  ipv4_cidr_text_parser_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Pending character words and expected parse results.
  char_word_t  char_q[$];
  res_t        parsed_q[$];
  logic [7:0]  line_q[$];
  char_word_t  next_word;
  res_t        want;
  int unsigned words_total;
  int unsigned words_done;
  int unsigned directed_words;
  int unsigned fail_cnt;
  int unsigned cycle_cnt;

  // Line scanner state of the model.
  seg_e        line_seg;
  int unsigned kept_cnt;
  logic [63:0] part_acc;
  num_ph_e     part_ph;
  logic [7:0]  prev_parts[3];
  int unsigned parts_seen;
  logic [31:0] addr_hold;
  bit          addr_invalid;
  int unsigned pfx_len;
  pfx_ph_e     pfx_state;
  bit          saw_dot;

  function automatic bit is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  // 16 flags a non-hex character.
  function automatic int unsigned hex_digit(logic [7:0] c);
    if (is_digit(c)) return c - "0";
    if ((c >= "a") && (c <= "f")) return c - "a" + 10;
    if ((c >= "A") && (c <= "F")) return c - "A" + 10;
    return 16;
  endfunction

  function automatic void clear_number();
    part_acc   = '0;
    part_ph    = PH_EXPECT;
    parts_seen = 0;
    foreach (prev_parts[i]) prev_parts[i] = '0;
  endfunction

  function automatic void clear_line();
    line_seg     = SEG_ADDR;
    kept_cnt     = 0;
    clear_number();
    addr_hold    = '0;
    addr_invalid = 1'b0;
    pfx_len      = 0;
    pfx_state    = PF_WS;
    saw_dot      = 1'b0;
  endfunction

  function automatic void add_digit(int unsigned base, int unsigned d);
    logic [63:0] v;
    v = part_acc * base + d;
    if (v > WORD_MAX) part_ph = PH_FAIL;
    else part_acc = v;
  endfunction

  function automatic void feed_number(logic [7:0] c);
    int unsigned hv;
    hv = hex_digit(c);
    if (part_ph == PH_FAIL || part_ph == PH_DONE) return;
    if (c == ".") begin
      if (part_ph == PH_EXPECT || part_ph == PH_HEXPRE || parts_seen >= 3 ||
          part_acc > 64'hFF) begin
        part_ph = PH_FAIL;
      end else begin
        prev_parts[parts_seen] = part_acc[7:0];
        parts_seen++;
        part_acc = '0;
        part_ph  = PH_EXPECT;
      end
      return;
    end
    case (part_ph)
      PH_EXPECT: begin
        if (!is_digit(c)) begin
          part_ph = PH_FAIL;
        end else if (c == "0") begin
          part_acc = '0;
          part_ph  = PH_ZERO;
        end else begin
          part_acc = c - "0";
          part_ph  = PH_DEC;
        end
      end
      PH_ZERO, PH_OCT: begin
        if (part_ph == PH_ZERO && (c == "x" || c == "X")) begin
          part_ph = PH_HEXPRE;
        end else if (is_digit(c)) begin
          if (c > "7") begin
            part_ph = PH_FAIL;
          end else begin
            add_digit(8, c - "0");
            if (part_ph != PH_FAIL) part_ph = PH_OCT;
          end
        end else if (is_blank(c)) begin
          part_ph = PH_DONE;
        end else begin
          part_ph = PH_FAIL;
        end
      end
      PH_DEC: begin
        if (is_digit(c)) add_digit(10, c - "0");
        else if (is_blank(c)) part_ph = PH_DONE;
        else part_ph = PH_FAIL;
      end
      PH_HEXPRE: begin
        if (hv < 16) begin
          part_acc = hv;
          part_ph  = PH_HEX;
        end else begin
          part_ph = PH_FAIL;
        end
      end
      default: begin
        if (hv < 16) add_digit(16, hv);
        else if (is_blank(c)) part_ph = PH_DONE;
        else part_ph = PH_FAIL;
      end
    endcase
  endfunction

  // Place the parts by their count; zero and 0 returned when the text is bad.
  function automatic bit finish_number(output logic [31:0] val);
    val = '0;
    if (part_ph == PH_EXPECT || part_ph == PH_HEXPRE || part_ph == PH_FAIL) return 1'b0;
    case (parts_seen)
      0: val = part_acc[31:0];
      1: begin
        if (part_acc > 64'hFF_FFFF) return 1'b0;
        val = {prev_parts[0], part_acc[23:0]};
      end
      2: begin
        if (part_acc > 64'hFFFF) return 1'b0;
        val = {prev_parts[0], prev_parts[1], part_acc[15:0]};
      end
      default: begin
        if (part_acc > 64'hFF) return 1'b0;
        val = {prev_parts[0], prev_parts[1], prev_parts[2], part_acc[7:0]};
      end
    endcase
    return 1'b1;
  endfunction

  // Leading-integer prefix length, saturating.
  function automatic void feed_prefix(logic [7:0] c);
    int unsigned nxt;
    if (pfx_state == PF_WS) begin
      if (is_blank(c)) return;
      if (c == "+") begin
        pfx_state = PF_DIGITS;
        return;
      end
      if (is_digit(c)) begin
        pfx_len   = c - "0";
        pfx_state = PF_DIGITS;
        return;
      end
      pfx_len   = 0;
      pfx_state = PF_DONE;
    end else if (pfx_state == PF_DIGITS) begin
      if (is_digit(c)) begin
        nxt     = pfx_len * 10 + (c - "0");
        pfx_len = (nxt > PREFIX_SAT) ? PREFIX_SAT : nxt;
      end else begin
        pfx_state = PF_DONE;
      end
    end
  endfunction

  // Advance the model by one accepted word; the last word queues a result.
  function automatic void parse_char(logic [7:0] c, logic lst);
    res_t        r;
    logic [31:0] v;
    if (c == 8'h00) begin
      if (line_seg == SEG_ADDR) line_seg = SEG_ADDR_END;
      else if (line_seg == SEG_MASK) line_seg = SEG_MASK_END;
    end else if (line_seg == SEG_ADDR) begin
      if (c == "/") begin
        addr_invalid = !finish_number(addr_hold);
        clear_number();
        line_seg = SEG_MASK;
      end else if ((is_digit(c) || c == ".") && kept_cnt < MAX_ADDR_CHARS_DEF) begin
        kept_cnt++;
        feed_number(c);
      end
    end else if (line_seg == SEG_MASK) begin
      if (c == ".") saw_dot = 1'b1;
      feed_number(c);
      feed_prefix(c);
    end
    if (!lst) return;
    r            = '0;
    r.status     = ST_OK;
    r.mask_given = (line_seg == SEG_MASK || line_seg == SEG_MASK_END);
    if (r.mask_given) begin
      if (saw_dot) begin
        if (!finish_number(v)) r.status = ST_BAD_MASK;
        else r.mask = v;
      end else if (pfx_len < 1 || pfx_len > 32) begin
        r.status = ST_BAD_PREFIX;
      end else begin
        r.mask = MASK_ONES << (32 - pfx_len);
      end
      if (r.status == ST_OK) begin
        if (addr_invalid) r.status = ST_BAD_ADDR;
        else r.address = addr_hold;
      end else begin
        r.mask = '0;
      end
    end else if (!finish_number(v)) begin
      r.status = ST_BAD_ADDR;
    end else begin
      r.address = v;
    end
    parsed_q.push_back(r);
    clear_line();
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic void emit_line();
    char_word_t w;
    if (line_q.size() == 0) line_q.push_back(8'($urandom_range(0, 255)));
    foreach (line_q[i]) begin
      w.ch   = line_q[i];
      w.last = (i == line_q.size() - 1);
      char_q.push_back(w);
    end
    line_q.delete();
  endfunction

  function automatic void text_line(string s);
    add_text(s);
    emit_line();
  endfunction

  // Part value that fits its room mostly, sometimes one over, sometimes past 32 bits.
  function automatic logic [63:0] pick_part(int unsigned room_bits);
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return {32'd0, $urandom()} & ((64'd1 << room_bits) - 64'd1);
      2: return 64'd1 << room_bits;
      3: return {32'd1, $urandom()};
      default: return 64'($urandom_range(0, 255));
    endcase
  endfunction

  // One number in decimal, octal or hex, or a malformed part.
  function automatic string num_text(logic [63:0] v);
    string s;
    case ($urandom_range(0, 11))
      0, 1, 2, 3, 4: s = $sformatf("%0d", v);
      5, 6: s = $sformatf("0%0o", v);
      7: s = $sformatf("0x%0h", v);
      8: begin
        s = $sformatf("0x%0h", v);
        s = s.toupper();
      end
      9: s = "";
      10: s = "0x";
      default: s = ($urandom_range(0, 1) == 0) ? "089" : "1a";
    endcase
    return s;
  endfunction

  function automatic string addr_text();
    int unsigned n;
    string       s;
    n = $urandom_range(1, 4);
    s = "";
    for (int i = 0; i < n; i++) begin
      if (i != 0) s = {s, "."};
      s = {s, num_text(pick_part((i == n - 1) ? 32 - 8 * (n - 1) : 8))};
    end
    if ($urandom_range(0, 19) == 0) s = {s, "."};
    return s;
  endfunction

  function automatic string mask_text();
    int unsigned len;
    logic [31:0] m;
    string       s;
    len = $urandom_range(1, 32);
    m   = MASK_ONES << (32 - len);
    case ($urandom_range(0, 12))
      0, 1, 2, 3: s = $sformatf("%0d", len);
      4: s = $sformatf("%0d", $urandom_range(0, 99));
      5: s = $sformatf(" \t+%0d", len);
      6: s = $sformatf("-%0d", len);
      7: s = $sformatf("%0d", $urandom());
      8, 9: s = $sformatf("%0d.%0d.%0d.%0d", m[31:24], m[23:16], m[15:8], m[7:0]);
      10: s = {num_text(m[31:24]), ".", num_text(m[23:16]), ".",
               num_text(m[15:8]), ".", num_text(m[7:0])};
      11: s = {num_text(m[31:24]), ".", num_text(m[23:0])};
      default: s = addr_text();
    endcase
    case ($urandom_range(0, 7))
      0: s = {s, " "};
      1: s = {s, "x"};
      2: s = {s, " 7"};
      default: ;
    endcase
    return s;
  endfunction

  function automatic void random_line();
    int unsigned kind;
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      // raw noise, any byte value
      repeat ($urandom_range(1, 20)) line_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 9) == 0) add_text(" ab");
      add_text(addr_text());
      // over-long address text, which can run past the kept-character limit
      if (kind == 2) add_text({".", addr_text()});
      if ($urandom_range(0, 3) != 0) begin
        line_q.push_back("/");
        add_text(mask_text());
      end
      if ($urandom_range(0, 9) == 0) begin
        line_q.push_back(8'h00);
        repeat ($urandom_range(0, 6)) line_q.push_back(8'($urandom_range(0, 255)));
      end
      // broken sequence: stray bytes dropped in anywhere
      if (kind == 3) begin
        repeat ($urandom_range(1, 3))
          line_q.insert($urandom_range(0, line_q.size()), 8'($urandom_range(0, 255)));
      end
    end
    emit_line();
  endfunction

  function automatic void directed_lines();
    text_line("1.2.3.4");
    text_line("255.255.255.255/32");
    text_line("0.0.0.0/1");
    text_line("10.1.2.3/0");
    text_line("10.1.2.3/33");
    text_line("1.2.3.4/-8");
    text_line("1.2.3.4/+16");
    text_line("1.2.3.4/ \t24x");
    text_line("1.2.3.4/123456789");
    text_line("1.2.3.4/255.255.255.0");
    text_line("9.8.7.6/0xff.0XFF.0.0 ");
    text_line("9.8.7.6/255.255.255.");
    text_line("9.8.7.6/255.256.0.0");
    text_line("1.2.3./24");
    text_line("/8");
    text_line("0x7f.01.0377.9");
    text_line("017.08.1.1");
    text_line("4294967295");
    text_line("4294967296");
    text_line("1.16777215/0x");
    text_line("ab1.c2.3.4 z");
    text_line("255.255.255.2551");
    // zero byte ends the text; the rest of the line is dropped
    add_text("1.2.3.4");
    line_q.push_back(8'h00);
    add_text("/24x");
    emit_line();
    add_text("1.2.3.4/8");
    line_q.push_back(8'h00);
    add_text("zz");
    emit_line();
    line_q.push_back(8'h00);
    emit_line();
  endfunction

  // ---------------------------------------------------------------- traffic
  function automatic int unsigned cur_phase();
    int unsigned p;
    if (words_total == 0) return 0;
    p = words_done * 4 / words_total;
    return (p > 3) ? 3 : p;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  // Driver: feeds character words, models each accepted one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_bus.ch    <= '0;
      in_bus.last  <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        parse_char(in_bus.ch, in_bus.last);
        words_done++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (char_q.size() != 0 && $urandom_range(0, 99) >= SEND_IDLE[cur_phase()]) begin
          next_word = char_q.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.ch    <= next_word.ch;
          in_bus.last  <= next_word.last;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result word against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (parsed_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h %h %b %0d", $time,
                   out_bus.address, out_bus.mask, out_bus.mask_given, out_bus.status);
          fail_cnt++;
        end else begin
          want = parsed_q.pop_front();
          check_field("address", want.address, out_bus.address);
          check_field("mask", want.mask, out_bus.mask);
          check_field("mask_given", 32'(want.mask_given), 32'(out_bus.mask_given));
          check_field("status", 32'(want.status), 32'(out_bus.status));
        end
      end
      out_bus.ready <= ($urandom_range(0, 99) >= RECV_STALL[cur_phase()]);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    in_bus.valid  = 1'b0;
    in_bus.ch     = '0;
    in_bus.last   = 1'b0;
    out_bus.ready = 1'b0;
    words_total   = 0;
    words_done    = 0;
    fail_cnt      = 0;
    cycle_cnt     = 0;
    clear_line();
    directed_lines();
    directed_words = char_q.size();
    while (char_q.size() - directed_words < RANDOM_WORDS) random_line();
    words_total = char_q.size();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (words_done != words_total) @(posedge clk_i);
    while (parsed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && parsed_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
